// ----- src/iprm_pkg.sv -----
`default_nettype none

package iprm_pkg;

    // Capacity of the point store and the widths that follow from it
    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;

    // Field widths
    localparam int COORD_W  = 16;
    localparam int RADIUS_W = 15;
    localparam int R2_W     = 2 * RADIUS_W;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int SQ_W     = 2 * COORD_W;
    localparam int SUM_W    = SQ_W + 1;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(200);

    typedef logic [IDX_W-1:0]           idx_t;
    typedef logic [CNT_W-1:0]           cnt_t;
    typedef logic signed [COORD_W-1:0]  coord_t;
    typedef logic [2*COORD_W-1:0]       point_word_t;

endpackage

`default_nettype wire

// ----- src/iprm_if.sv -----
`default_nettype none

// Point input channel
interface iprm_point_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] x_mm;
    logic signed [15:0] y_mm;
    logic               last;

    modport source (output valid, output x_mm, output y_mm, output last, input ready);
    modport sink   (input valid, input x_mm, input y_mm, input last, output ready);
endinterface

// Result output channel
interface iprm_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_x_mm;
    logic signed [15:0] out_y_mm;
    logic               kept;
    logic               overflowed;
    logic               last_out;

    modport source (output valid, output out_x_mm, output out_y_mm, output kept,
                    output overflowed, output last_out, input ready);
    modport sink   (input valid, input out_x_mm, input out_y_mm, input kept,
                    input overflowed, input last_out, output ready);
endinterface

// Radius register write channel
interface iprm_cfg_if;
    logic        valid;
    logic        ready;
    logic [14:0] radius_mm;

    modport source (output valid, output radius_mm, input ready);
    modport sink   (input valid, input radius_mm, output ready);
endinterface

`default_nettype wire

// ----- src/isolated_point_removal_2d_core.sv -----
`default_nettype none

// Radius outlier removal over a scan of 2D points.
// Channels: point (x_mm, y_mm, last) in, result (out_x_mm, out_y_mm, kept,
// overflowed, last_out) out, cfg writes the radius. All use valid/ready; an
// item moves on a clock edge with both high. cfg is always ready.
// Loading takes one point per cycle into a 64-entry store; points beyond
// capacity are dropped and the scan's results carry overflowed = 1.
// After the last point, each of the N stored points gets a row scan: read the
// point on the first read port, issue all N stored points (the self-pair is
// masked) on the second read port of the store, run the difference/square/
// compare pipeline until it drains, then emit. The pairwise compare pipeline,
// fed one stored point per cycle, sets the pace of the scan. No point is taken
// while results of a scan are being produced.
// A stalled receiver holds the result register; the next row does not start
// its emit until that result is taken.
// Reset empties the store (count zero), clears the overflow mark, drops any
// pending result and sets the radius to 200 mm.
module isolated_point_removal_2d_core
    import iprm_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    iprm_cfg_if.sink             cfg,
    iprm_point_if.sink           point,
    iprm_result_if.source        result
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ROW,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t                 state_reg;
    cnt_t                   count_reg;
    logic                   ovf_reg;
    idx_t                   i_reg;
    idx_t                   j_reg;
    logic                   found_reg;
    logic [RADIUS_W-1:0]    radius_reg;
    logic [R2_W-1:0]        r2_reg;

    point_word_t            pt_mem [MAX_POINTS];
    point_word_t            a_q;
    point_word_t            b_q;

    logic                   v1_reg, v2_reg, v3_reg;
    logic                   self1_reg, self2_reg, self3_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic [SQ_W-1:0]        sqx_reg, sqy_reg;

    logic                   out_valid_reg;
    coord_t                 out_x_reg, out_y_reg;
    logic                   out_kept_reg, out_ovf_reg, out_last_reg;

    logic                   load_fire;
    logic                   store_we;
    logic                   out_free;
    logic                   emit_fire;
    logic                   row_last;
    logic                   j_last;
    logic                   pipe_busy;
    logic [SUM_W-1:0]       d2;
    logic                   hit;
    logic signed [2*DIFF_W-1:0] px, py;

    // Handshakes
    assign cfg.ready   = 1'b1;
    assign point.ready = (state_reg == ST_LOAD);
    assign load_fire   = point.valid && point.ready;
    assign store_we    = load_fire && (count_reg != CNT_W'(MAX_POINTS));
    assign out_free    = !out_valid_reg || result.ready;
    assign emit_fire   = (state_reg == ST_EMIT) && out_free;
    assign row_last    = ({1'b0, i_reg} == CNT_W'(count_reg - CNT_W'(1)));
    assign j_last      = ({1'b0, j_reg} == CNT_W'(count_reg - CNT_W'(1)));
    assign pipe_busy   = v1_reg || v2_reg || v3_reg;

    // Point store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            pt_mem[count_reg[IDX_W-1:0]] <= {point.x_mm, point.y_mm};
        end
        a_q <= pt_mem[i_reg];
        b_q <= pt_mem[j_reg];
    end

    // Squares and distance compare
    assign px  = dx_reg * dx_reg;
    assign py  = dy_reg * dy_reg;
    assign d2  = SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
    assign hit = v3_reg && !self3_reg && (d2 <= SUM_W'(r2_reg));

    // Radius register and its square
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            r2_reg     <= R2_W'(RADIUS_RESET) * R2_W'(RADIUS_RESET);
        end
        else
        begin
            if (cfg.valid)
            begin
                radius_reg <= cfg.radius_mm;
            end
            r2_reg <= R2_W'(radius_reg) * R2_W'(radius_reg);
        end
    end

    // Compare pipeline payload
    always_ff @(posedge clk)
    begin
        dx_reg    <= DIFF_W'(signed'(a_q[2*COORD_W-1:COORD_W]))
                   - DIFF_W'(signed'(b_q[2*COORD_W-1:COORD_W]));
        dy_reg    <= DIFF_W'(signed'(a_q[COORD_W-1:0]))
                   - DIFF_W'(signed'(b_q[COORD_W-1:0]));
        sqx_reg   <= px[SQ_W-1:0];
        sqy_reg   <= py[SQ_W-1:0];
        self2_reg <= self1_reg;
        self3_reg <= self2_reg;
    end

    // Sequencer, pipeline valids and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            found_reg     <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            self1_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_kept_reg  <= 1'b0;
            out_ovf_reg   <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            // advance the compare pipeline
            v1_reg    <= (state_reg == ST_SCAN);
            self1_reg <= (j_reg == i_reg);
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            if (hit)
            begin
                found_reg <= 1'b1;
            end

            // drop the result once taken, unless a new one replaces it
            if (result.ready && !emit_fire)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_LOAD:
                begin
                    if (load_fire)
                    begin
                        if (store_we)
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (point.last)
                        begin
                            i_reg     <= '0;
                            found_reg <= 1'b0;
                            state_reg <= ST_ROW;
                        end
                    end
                end
                ST_ROW:
                begin
                    // wait for the row point to appear on the first read port
                    j_reg     <= '0;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (j_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        j_reg <= j_reg + IDX_W'(1);
                    end
                end
                ST_DRAIN:
                begin
                    if (!pipe_busy)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_x_reg     <= a_q[2*COORD_W-1:COORD_W];
                        out_y_reg     <= a_q[COORD_W-1:0];
                        out_kept_reg  <= found_reg;
                        out_ovf_reg   <= ovf_reg;
                        out_last_reg  <= row_last;
                        found_reg     <= 1'b0;
                        if (row_last)
                        begin
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= ST_LOAD;
                        end
                        else
                        begin
                            i_reg     <= i_reg + IDX_W'(1);
                            state_reg <= ST_ROW;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.out_x_mm   = out_x_reg;
    assign result.out_y_mm   = out_y_reg;
    assign result.kept       = out_kept_reg;
    assign result.overflowed = out_ovf_reg;
    assign result.last_out   = out_last_reg;

`ifndef SYNTHESIS
    // The compare pipeline is empty whenever points are being loaded
    a_load_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> !pipe_busy)
        else $error("compare pipeline busy during load");

    // The store count never passes capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond capacity");

    // Row scans only run over a non-empty store
    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> (count_reg != '0))
        else $error("row scan with empty store");

    // A result is emitted only into a free output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_valid_reg && !result.ready)
        |=> $stable(out_x_reg) && $stable(out_last_reg))
        else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire
